>>> src/ifmt_pkg.sv
// Package for the integer ASCII formatter: item structs, option and status
// structs, ASCII character codes and request/sign mode codes.
// No dependencies.
package ifmt_pkg;

    localparam int CNT_W = 5;

    localparam logic [1:0] REQ_UDEC = 2'd0;
    localparam logic [1:0] REQ_SDEC = 2'd1;
    localparam logic [1:0] REQ_HEX  = 2'd2;

    localparam logic [1:0] SIGN_MINUS  = 2'd0;
    localparam logic [1:0] SIGN_ALWAYS = 2'd1;
    localparam logic [1:0] SIGN_NEVER  = 2'd2;

    localparam logic [7:0] CH_ZERO  = 8'h30;
    localparam logic [7:0] CH_SPACE = 8'h20;
    localparam logic [7:0] CH_MINUS = 8'h2D;
    localparam logic [7:0] CH_PLUS  = 8'h2B;
    localparam logic [7:0] CH_LOWX  = 8'h78;
    localparam logic [7:0] CH_UPX   = 8'h58;
    localparam logic [7:0] CH_LOWA  = 8'h61;
    localparam logic [7:0] CH_UPA   = 8'h41;

    localparam logic [3:0] DIG_TEN  = 4'd10;

    typedef struct packed {
        logic [1:0]  req_type;
        logic [63:0] value;
        logic [4:0]  field_width;
        logic        precision_given;
        logic [4:0]  min_digits;
        logic        pad_zero;
        logic        left_justify;
        logic [1:0]  sign_mode;
        logic        prefix_enable;
        logic        upper_case;
    } t_in_item;

    typedef struct packed {
        logic [7:0] char_out;
        logic       last_char;
    } t_out_item;

    typedef struct packed {
        logic       hex;
        logic       sign_en;
        logic       sign_minus;
        logic [4:0] width;
        logic [4:0] prec;
        logic       pad_zero;
        logic       left;
        logic       prefix;
        logic       upper;
    } t_fmt_opts;

    typedef struct packed {
        logic             done;
        logic [CNT_W-1:0] count;
        logic [3:0]       digit;
    } t_dig_stat;

endpackage

>>> src/ifmt_digits.sv
// Digit engine: decimal values take bit-serial binary to BCD conversion
// (shift and add-3), hex values load directly; leading zero removal one
// digit per cycle, then digit pop on request. Depends on ifmt_pkg.
module ifmt_digits import ifmt_pkg::*; #(
    parameter int VALUE_BITS = 64
) (
    input  logic                  i_clk,
    input  logic                  i_rst_n,
    input  logic                  i_start,
    input  logic                  i_hex,
    input  logic [VALUE_BITS-1:0] i_mag,
    input  logic                  i_shift,
    output t_dig_stat             o_stat
);

    localparam int DEC_DIGITS = (VALUE_BITS * 30103) / 100000 + 1;
    localparam int HEX_DIGITS = (VALUE_BITS + 3) / 4;
    localparam int NDIG       = (DEC_DIGITS > HEX_DIGITS) ? DEC_DIGITS : HEX_DIGITS;
    localparam int BW         = NDIG * 4;
    localparam int CW         = $clog2(VALUE_BITS + 1);

    typedef enum logic [1:0] {
        S_IDLE,
        S_CONV,
        S_NORM,
        S_READY
    } t_dstate;

    t_dstate               r_state, n_state;
    logic [VALUE_BITS-1:0] r_bin, n_bin;
    logic [BW-1:0]         r_bcd, n_bcd;
    logic [BW-1:0]         adj;
    logic [CW-1:0]         r_cnt, n_cnt;
    logic [CNT_W-1:0]      r_nd, n_nd;

    always_comb begin
        for (int k = 0; k < NDIG; k++) begin
            adj[4*k +: 4] = (r_bcd[4*k +: 4] >= 4'd5) ? r_bcd[4*k +: 4] + 4'd3
                                                      : r_bcd[4*k +: 4];
        end
    end

    always_comb begin
        n_state = r_state;
        n_bin   = r_bin;
        n_bcd   = r_bcd;
        n_cnt   = r_cnt;
        n_nd    = r_nd;
        if (i_start) begin
            n_nd = CNT_W'(NDIG);
            if (i_hex) begin
                n_bcd   = {{(BW - VALUE_BITS){1'b0}}, i_mag};
                n_state = S_NORM;
            end else begin
                n_bin   = i_mag;
                n_bcd   = '0;
                n_cnt   = CW'(VALUE_BITS);
                n_state = S_CONV;
            end
        end else begin
            case (r_state)
                S_CONV: begin
                    n_bcd = {adj[BW-2:0], r_bin[VALUE_BITS-1]};
                    n_bin = {r_bin[VALUE_BITS-2:0], 1'b0};
                    n_cnt = r_cnt - CW'(1);
                    if (r_cnt == CW'(1)) begin
                        n_state = S_NORM;
                    end
                end
                S_NORM: begin
                    if (r_nd > CNT_W'(1) && r_bcd[BW-1 -: 4] == 4'd0) begin
                        n_bcd = {r_bcd[BW-5:0], 4'd0};
                        n_nd  = r_nd - CNT_W'(1);
                    end else begin
                        n_state = S_READY;
                    end
                end
                S_READY: begin
                    if (i_shift) begin
                        n_bcd = {r_bcd[BW-5:0], 4'd0};
                    end
                end
                default: begin
                    n_state = S_IDLE;
                end
            endcase
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
        r_bin <= n_bin;
        r_bcd <= n_bcd;
        r_cnt <= n_cnt;
        r_nd  <= n_nd;
    end

    assign o_stat.done  = (r_state == S_READY);
    assign o_stat.count = r_nd;
    assign o_stat.digit = r_bcd[BW-1 -: 4];

endmodule

>>> src/ifmt_emit.sv
// Character sequencer: sizes sign, prefix, padding, zero fill and digit runs,
// then emits one character per cycle into the output register unless stalled.
// Depends on ifmt_pkg and the status of ifmt_digits.
module ifmt_emit import ifmt_pkg::*; (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_start,
    input  t_fmt_opts i_opts,
    input  t_dig_stat i_stat,
    output logic      o_shift,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall,
    output logic      o_done
);

    typedef enum logic [3:0] {
        P_IDLE,
        P_WAIT,
        P_SIGN,
        P_PREA,
        P_LPAD,
        P_PREB,
        P_ZERO,
        P_DIG,
        P_RPAD
    } t_phase;

    t_phase     r_phase, n_phase;
    t_fmt_opts  r_opts, n_opts;
    logic [4:0] r_c_sign, n_c_sign;
    logic [4:0] r_c_prea, n_c_prea;
    logic [4:0] r_c_lpad, n_c_lpad;
    logic [4:0] r_c_preb, n_c_preb;
    logic [4:0] r_c_zero, n_c_zero;
    logic [4:0] r_c_dig,  n_c_dig;
    logic [4:0] r_c_rpad, n_c_rpad;
    logic [5:0] r_left,   n_left;
    logic       r_out_valid, n_out_valid;
    t_out_item  r_out, n_out;

    logic [4:0] nd, padn, zeron, cur;
    logic       has_pre, room, fire;
    logic [7:0] ch, pad_ch, x_ch, dig_ch;
    t_phase     nxt;

    assign nd      = i_stat.count;
    assign padn    = (r_opts.width > nd) ? r_opts.width - nd : 5'd0;
    assign zeron   = (!r_opts.hex && r_opts.prec > nd) ? r_opts.prec - nd : 5'd0;
    assign has_pre = r_opts.hex && r_opts.prefix && !r_opts.left;
    assign room    = !r_out_valid || !i_out_stall;
    assign pad_ch  = r_opts.pad_zero ? CH_ZERO : CH_SPACE;
    assign x_ch    = r_opts.upper ? CH_UPX : CH_LOWX;

    always_comb begin
        if (r_opts.hex && i_stat.digit >= DIG_TEN) begin
            dig_ch = {4'd0, i_stat.digit - DIG_TEN} + (r_opts.upper ? CH_UPA : CH_LOWA);
        end else begin
            dig_ch = {4'd0, i_stat.digit} + CH_ZERO;
        end
    end

    always_comb begin
        cur = 5'd0;
        ch  = CH_SPACE;
        nxt = P_IDLE;
        case (r_phase)
            P_SIGN: begin
                cur = r_c_sign;
                ch  = r_opts.sign_minus ? CH_MINUS : CH_PLUS;
                nxt = P_PREA;
            end
            P_PREA: begin
                cur = r_c_prea;
                ch  = (r_c_prea == 5'd2) ? CH_ZERO : x_ch;
                nxt = P_LPAD;
            end
            P_LPAD: begin
                cur = r_c_lpad;
                ch  = pad_ch;
                nxt = P_PREB;
            end
            P_PREB: begin
                cur = r_c_preb;
                ch  = (r_c_preb == 5'd2) ? CH_ZERO : x_ch;
                nxt = P_ZERO;
            end
            P_ZERO: begin
                cur = r_c_zero;
                ch  = CH_ZERO;
                nxt = P_DIG;
            end
            P_DIG: begin
                cur = r_c_dig;
                ch  = dig_ch;
                nxt = P_RPAD;
            end
            P_RPAD: begin
                cur = r_c_rpad;
                ch  = pad_ch;
                nxt = P_IDLE;
            end
            default: begin
                cur = 5'd0;
            end
        endcase
    end

    assign fire    = (cur != 5'd0) && room;
    assign o_shift = fire && (r_phase == P_DIG);

    always_comb begin
        n_phase     = r_phase;
        n_opts      = r_opts;
        n_c_sign    = r_c_sign;
        n_c_prea    = r_c_prea;
        n_c_lpad    = r_c_lpad;
        n_c_preb    = r_c_preb;
        n_c_zero    = r_c_zero;
        n_c_dig     = r_c_dig;
        n_c_rpad    = r_c_rpad;
        n_left      = r_left;
        n_out_valid = r_out_valid && i_out_stall;
        n_out       = r_out;
        case (r_phase)
            P_IDLE: begin
                if (i_start) begin
                    n_opts  = i_opts;
                    n_phase = P_WAIT;
                end
            end
            P_WAIT: begin
                if (i_stat.done) begin
                    n_c_sign = {4'd0, r_opts.sign_en};
                    n_c_prea = (has_pre && r_opts.pad_zero) ? 5'd2 : 5'd0;
                    n_c_preb = (has_pre && !r_opts.pad_zero) ? 5'd2 : 5'd0;
                    n_c_lpad = r_opts.left ? 5'd0 : padn;
                    n_c_rpad = r_opts.left ? padn : 5'd0;
                    n_c_zero = zeron;
                    n_c_dig  = nd;
                    n_left   = {5'd0, r_opts.sign_en} + {1'b0, n_c_prea} + {1'b0, n_c_preb}
                             + {1'b0, padn} + {1'b0, zeron} + {1'b0, nd};
                    n_phase  = P_SIGN;
                end
            end
            default: begin
                if (cur == 5'd0) begin
                    n_phase = nxt;
                end else if (fire) begin
                    n_out.char_out  = ch;
                    n_out.last_char = (r_left == 6'd1);
                    n_out_valid     = 1'b1;
                    n_left          = r_left - 6'd1;
                    case (r_phase)
                        P_SIGN:  n_c_sign = r_c_sign - 5'd1;
                        P_PREA:  n_c_prea = r_c_prea - 5'd1;
                        P_LPAD:  n_c_lpad = r_c_lpad - 5'd1;
                        P_PREB:  n_c_preb = r_c_preb - 5'd1;
                        P_ZERO:  n_c_zero = r_c_zero - 5'd1;
                        P_DIG:   n_c_dig  = r_c_dig - 5'd1;
                        P_RPAD:  n_c_rpad = r_c_rpad - 5'd1;
                        default: n_left   = r_left - 6'd1;
                    endcase
                    if (r_left == 6'd1) begin
                        n_phase = P_IDLE;
                    end
                end
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase     <= P_IDLE;
            r_out_valid <= 1'b0;
            r_left      <= 6'd0;
        end else begin
            r_phase     <= n_phase;
            r_out_valid <= n_out_valid;
            r_left      <= n_left;
        end
        r_opts   <= n_opts;
        r_c_sign <= n_c_sign;
        r_c_prea <= n_c_prea;
        r_c_lpad <= n_c_lpad;
        r_c_preb <= n_c_preb;
        r_c_zero <= n_c_zero;
        r_c_dig  <= n_c_dig;
        r_c_rpad <= n_c_rpad;
        r_out    <= n_out;
    end

    assign o_out_valid = r_out_valid;
    assign o_out_data  = r_out;
    assign o_done      = r_out_valid && !i_out_stall && r_out.last_char;

    a_last_drains: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && r_out.last_char) |-> (r_left == 6'd0))
        else $error("last character shown with characters still owed");

    a_pop_ready: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_shift |-> i_stat.done)
        else $error("digit popped before conversion finished");

    a_done_waits: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        $rose(i_stat.done) |-> (r_phase == P_WAIT))
        else $error("digits ready while sequencer not waiting");

endmodule

>>> src/integer_ascii_formatter_top.sv
// Top level of the integer ASCII formatter: input handshake, sign and
// magnitude, option saturation. Depends on ifmt_pkg, ifmt_digits, ifmt_emit.
//
//  channel | direction | handshake                     | payload
//  in      | input     | i_in_valid / o_in_stall       | i_in_data  (t_in_item)
//  out     | output    | o_out_valid / i_out_stall     | o_out_data (t_out_item)
//
// One item at a time: the input stalls from acceptance until its last
// character is taken. Decimal items pass through the shift and add-3
// converter, hex items skip it; leading zero removal and sizing follow, then
// one character per cycle while the output is not stalled, with phase steps
// between the runs. Reset is synchronous and clears control only. An output
// stall holds the output register and pauses the character sequencer.
module integer_ascii_formatter_top import ifmt_pkg::*; #(
    parameter int VALUE_BITS  = 64,
    parameter int FIELD_LIMIT = 31
) (
    input  logic      i_clk,
    input  logic      i_rst_n,
    input  logic      i_in_valid,
    input  t_in_item  i_in_data,
    output logic      o_in_stall,
    output logic      o_out_valid,
    output t_out_item o_out_data,
    input  logic      i_out_stall
);

    localparam logic [4:0] FL5 = 5'(FIELD_LIMIT);

    logic                  r_busy;
    logic                  acc, done, shift;
    logic                  is_hex, is_sdec, neg;
    logic [VALUE_BITS-1:0] v, mag;
    logic [4:0]            wsat, msat;
    t_fmt_opts             opts;
    t_dig_stat             stat;

    assign acc     = i_in_valid && !r_busy;
    assign is_hex  = (i_in_data.req_type == REQ_HEX);
    assign is_sdec = (i_in_data.req_type == REQ_SDEC);
    assign v       = i_in_data.value[VALUE_BITS-1:0];
    assign neg     = is_sdec && v[VALUE_BITS-1];
    assign mag     = neg ? (~v + VALUE_BITS'(1)) : v;
    assign wsat    = (i_in_data.field_width > FL5) ? FL5 : i_in_data.field_width;
    assign msat    = (i_in_data.min_digits > FL5) ? FL5 : i_in_data.min_digits;

    always_comb begin
        opts.hex        = is_hex;
        opts.sign_minus = neg;
        opts.sign_en    = neg ? (i_in_data.sign_mode != SIGN_NEVER)
                              : (is_sdec && i_in_data.sign_mode == SIGN_ALWAYS);
        opts.width      = wsat;
        opts.prec       = i_in_data.precision_given ? msat : 5'd1;
        opts.pad_zero   = i_in_data.pad_zero;
        opts.left       = i_in_data.left_justify;
        opts.prefix     = i_in_data.prefix_enable;
        opts.upper      = i_in_data.upper_case;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
        end else if (acc) begin
            r_busy <= 1'b1;
        end else if (done) begin
            r_busy <= 1'b0;
        end
    end

    assign o_in_stall = r_busy;

    ifmt_digits #(
        .VALUE_BITS(VALUE_BITS)
    ) u_digits (
        .i_clk   (i_clk),
        .i_rst_n (i_rst_n),
        .i_start (acc),
        .i_hex   (is_hex),
        .i_mag   (mag),
        .i_shift (shift),
        .o_stat  (stat)
    );

    ifmt_emit u_emit (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_start     (acc),
        .i_opts      (opts),
        .i_stat      (stat),
        .o_shift     (shift),
        .o_out_valid (o_out_valid),
        .o_out_data  (o_out_data),
        .i_out_stall (i_out_stall),
        .o_done      (done)
    );

endmodule

>>> verif/integer_ascii_formatter_top_test.sv
// Self-checking testbench for integer_ascii_formatter_top: a directed table and then random
// numbers, with characters checked against a formatter model written here.
// Depends on ifmt_pkg and the formatter RTL.
module integer_ascii_formatter_top_test;
    import ifmt_pkg::*;

    localparam logic [1:0] REQ_SPARE  = 2'd3;
    localparam logic [1:0] SIGN_SPARE = 2'd3;
    localparam int RANDOM_ITEMS   = 95;
    localparam int HOLD_AT_CYCLE  = 3000;
    localparam int HOLD_CYCLES    = 400;
    localparam int DRAIN_CYCLES   = 200;
    localparam int MAX_PRINTED    = 100;
    localparam int TIMEOUT_UNITS  = 2000000;
    localparam int DIRECTED_ROWS  = 25;
    localparam int IN_W           = $bits(t_in_item);

    typedef struct {
        t_in_item item;
        string    text;
    } t_dir_row;

    logic      clk = 1'b0;
    logic      rst_n = 1'b0;
    logic      in_valid = 1'b0;
    t_in_item  in_data = '0;
    logic      in_stall;
    logic      out_valid;
    t_out_item out_data;
    logic      out_stall = 1'b0;

    t_out_item pending_chars[$];
    int        mismatch_count = 0;
    int        calm_items = 0;
    t_dir_row  directed_rows[DIRECTED_ROWS];

    integer_ascii_formatter_top u_dut (
        .i_clk       (clk),
        .i_rst_n     (rst_n),
        .i_in_valid  (in_valid),
        .i_in_data   (in_data),
        .o_in_stall  (in_stall),
        .o_out_valid (out_valid),
        .o_out_data  (out_data),
        .i_out_stall (out_stall)
    );

    always #1 clk = ~clk;

    task automatic report_mismatch(input string msg);
        if (mismatch_count < MAX_PRINTED) begin
            $display("MISMATCH: %s", msg);
        end
        mismatch_count++;
    endtask

    function automatic t_in_item mk(logic [1:0] req, logic [63:0] v, int w, bit pg, int md,
                                    bit pz, bit lj, logic [1:0] sm, bit pre, bit up);
        t_in_item it;
        it.req_type        = req;
        it.value           = v;
        it.field_width     = 5'(w);
        it.precision_given = pg;
        it.min_digits      = 5'(md);
        it.pad_zero        = pz;
        it.left_justify    = lj;
        it.sign_mode       = sm;
        it.prefix_enable   = pre;
        it.upper_case      = up;
        return it;
    endfunction

    task automatic queue_chars(ref logic [7:0] text[$]);
        t_out_item c;
        for (int i = 0; i < text.size(); i++) begin
            c.char_out  = text[i];
            c.last_char = (i == text.size() - 1);
            pending_chars.push_back(c);
        end
    endtask

    task automatic queue_text(input string s);
        logic [7:0] text[$];
        for (int i = 0; i < s.len(); i++) begin
            text.push_back(s[i]);
        end
        queue_chars(text);
    endtask

    task automatic format_number(input t_in_item it);
        logic [7:0]  text[$];
        logic [7:0]  digs[20];
        logic [7:0]  pad;
        logic [7:0]  xch;
        logic [63:0] mag;
        logic [3:0]  d;
        int          nd;
        int          width;
        int          prec;
        width = int'(it.field_width);
        prec  = it.precision_given ? int'(it.min_digits) : 1;
        pad   = it.pad_zero ? CH_ZERO : CH_SPACE;
        if (it.req_type == REQ_HEX) begin
            xch = it.upper_case ? CH_UPX : CH_LOWX;
            nd  = 1;
            mag = it.value;
            while (mag >= 64'd16) begin
                mag = mag >> 4;
                nd++;
            end
            if (it.prefix_enable && !it.left_justify && it.pad_zero) begin
                text.push_back(CH_ZERO);
                text.push_back(xch);
            end
            if (!it.left_justify && width > nd) repeat (width - nd) text.push_back(pad);
            if (it.prefix_enable && !it.left_justify && !it.pad_zero) begin
                text.push_back(CH_ZERO);
                text.push_back(xch);
            end
            for (int i = nd - 1; i >= 0; i--) begin
                d = 4'(it.value >> (4 * i));
                if (d < DIG_TEN) text.push_back(CH_ZERO + 8'(d));
                else text.push_back((it.upper_case ? CH_UPA : CH_LOWA) + 8'(d - DIG_TEN));
            end
            if (it.left_justify && width > nd) repeat (width - nd) text.push_back(pad);
        end else begin
            mag = it.value;
            if (it.req_type == REQ_SDEC) begin
                if (it.value[63]) begin
                    mag = -it.value;
                    if (it.sign_mode != SIGN_NEVER) text.push_back(CH_MINUS);
                end else if (it.sign_mode == SIGN_ALWAYS) begin
                    text.push_back(CH_PLUS);
                end
            end
            nd = 0;
            do begin
                digs[nd] = CH_ZERO + 8'(mag % 64'd10);
                nd++;
                mag = mag / 64'd10;
            end while (mag != 0 && nd < 20);
            if (!it.left_justify && width > nd) repeat (width - nd) text.push_back(pad);
            if (prec > nd) repeat (prec - nd) text.push_back(CH_ZERO);
            for (int i = nd - 1; i >= 0; i--) text.push_back(digs[i]);
            if (it.left_justify && width > nd) repeat (width - nd) text.push_back(pad);
        end
        while (text.size() > 62) void'(text.pop_back());
        queue_chars(text);
    endtask

    function automatic int next_gap();
        int r;
        if (calm_items > 0) begin
            calm_items--;
            return 0;
        end
        r = $urandom_range(0, 99);
        if (r < 8) begin
            calm_items = $urandom_range(5, 12);
            return 0;
        end
        if (r < 50) return 0;
        if (r < 92) return $urandom_range(1, 4);
        return $urandom_range(15, 40);
    endfunction

    task automatic send_item(input t_in_item it, input string text);
        int gap;
        gap = next_gap();
        if (gap > 0) begin
            in_valid <= 1'b0;
            repeat (gap) @(negedge clk);
        end
        in_valid <= 1'b1;
        in_data  <= it;
        do @(posedge clk); while (in_stall);
        if (text.len() == 0) format_number(it);
        else queue_text(text);
        @(negedge clk);
    endtask

    function automatic t_in_item random_item();
        t_in_item it;
        int r;
        it = IN_W'({$urandom, $urandom, $urandom});
        r = $urandom_range(0, 9);
        it.req_type = (r < 3) ? REQ_UDEC : (r < 6) ? REQ_SDEC : (r < 9) ? REQ_HEX : REQ_SPARE;
        r = $urandom_range(0, 9);
        it.sign_mode = (r < 4) ? SIGN_MINUS : (r < 7) ? SIGN_ALWAYS :
                       (r < 9) ? SIGN_NEVER : SIGN_SPARE;
        case ($urandom_range(0, 5))
            0: it.value = {$urandom, $urandom};
            1: it.value = 64'($urandom_range(0, 999));
            2: it.value = -64'($urandom_range(1, 1000));
            3: it.value = 64'd1 << $urandom_range(0, 63);
            4: it.value = ~64'd0 >> $urandom_range(0, 63);
            default: it.value = {$urandom, $urandom} >> $urandom_range(0, 63);
        endcase
        if ($urandom_range(0, 3) != 0) it.field_width = 5'($urandom_range(0, 12));
        if ($urandom_range(0, 3) != 0) it.min_digits = 5'($urandom_range(0, 12));
        return it;
    endfunction

    always @(posedge clk) begin : check_output
        t_out_item want;
        if (rst_n && out_valid && !out_stall) begin
            if (pending_chars.size() == 0) begin
                report_mismatch($sformatf("unexpected char %h last %b",
                                          out_data.char_out, out_data.last_char));
            end else begin
                want = pending_chars.pop_front();
                if (out_data.char_out !== want.char_out)
                    report_mismatch($sformatf("char_out %h, want %h",
                                              out_data.char_out, want.char_out));
                if (out_data.last_char !== want.last_char)
                    report_mismatch($sformatf("last_char %b, want %b on char %h",
                                              out_data.last_char, want.last_char,
                                              want.char_out));
            end
        end
    end

    initial begin : receiver
        int cycle;
        int run;
        logic level;
        cycle = 0;
        run = 0;
        level = 1'b0;
        @(posedge rst_n);
        forever begin
            @(negedge clk);
            cycle++;
            if (cycle == HOLD_AT_CYCLE) begin
                out_stall <= 1'b1;
                repeat (HOLD_CYCLES) @(negedge clk);
            end else begin
                if (run == 0) begin
                    case ($urandom_range(0, 19))
                        0, 1, 2, 3, 4: begin level = 1'b0; run = $urandom_range(20, 100); end
                        5, 6, 7, 8, 9, 10: begin level = 1'b0; run = $urandom_range(1, 4); end
                        18: begin level = 1'b1; run = $urandom_range(10, 20); end
                        default: begin level = 1'b1; run = $urandom_range(1, 3); end
                    endcase
                end
                run--;
                out_stall <= level;
            end
        end
    end

    initial begin : timeout
        #TIMEOUT_UNITS;
        $display("Regression FAIL");
        $finish;
    end

    initial begin : stimulus
        directed_rows[0]  = '{mk(REQ_UDEC, 64'd0, 0, 0, 0, 0, 0, SIGN_MINUS, 0, 0), "0"};
        directed_rows[1]  = '{mk(REQ_UDEC, 64'd0, 0, 1, 0, 0, 0, SIGN_MINUS, 0, 0), "0"};
        directed_rows[2]  = '{mk(REQ_UDEC, ~64'd0, 0, 0, 0, 0, 0, SIGN_MINUS, 0, 0),
                              "18446744073709551615"};
        directed_rows[3]  = '{mk(REQ_SDEC, ~64'd0, 0, 0, 0, 0, 0, SIGN_MINUS, 0, 0), "-1"};
        directed_rows[4]  = '{mk(REQ_SDEC, 64'h8000_0000_0000_0000, 0, 0, 0, 0, 0,
                                 SIGN_MINUS, 0, 0), "-9223372036854775808"};
        directed_rows[5]  = '{mk(REQ_SDEC, 64'h7FFF_FFFF_FFFF_FFFF, 0, 0, 0, 0, 0,
                                 SIGN_ALWAYS, 0, 0), "+9223372036854775807"};
        directed_rows[6]  = '{mk(REQ_SDEC, ~64'd4, 0, 0, 0, 0, 0, SIGN_NEVER, 0, 0), "5"};
        directed_rows[7]  = '{mk(REQ_SDEC, 64'd42, 0, 0, 0, 0, 0, SIGN_SPARE, 0, 0), "42"};
        directed_rows[8]  = '{mk(REQ_SPARE, 64'd123, 0, 0, 0, 0, 0, SIGN_ALWAYS, 0, 0), "123"};
        directed_rows[9]  = '{mk(REQ_HEX, 64'd0, 0, 0, 0, 0, 0, SIGN_MINUS, 0, 0), "0"};
        directed_rows[10] = '{mk(REQ_HEX, ~64'd0, 0, 0, 0, 0, 0, SIGN_MINUS, 1, 1),
                              "0XFFFFFFFFFFFFFFFF"};
        directed_rows[11] = '{mk(REQ_HEX, 64'd255, 6, 0, 0, 1, 0, SIGN_MINUS, 1, 0),
                              "0x0000ff"};
        directed_rows[12] = '{mk(REQ_HEX, 64'd255, 6, 0, 0, 0, 0, SIGN_MINUS, 1, 0),
                              "    0xff"};
        directed_rows[13] = '{mk(REQ_HEX, 64'd255, 6, 0, 0, 0, 1, SIGN_MINUS, 1, 0),
                              "ff    "};
        directed_rows[14] = '{mk(REQ_UDEC, 64'd7, 5, 0, 0, 0, 0, SIGN_MINUS, 0, 0), "    7"};
        directed_rows[15] = '{mk(REQ_UDEC, 64'd7, 5, 0, 0, 0, 1, SIGN_MINUS, 0, 0), "7    "};
        directed_rows[16] = '{mk(REQ_UDEC, 64'd7, 5, 0, 0, 1, 0, SIGN_MINUS, 0, 0), "00007"};
        directed_rows[17] = '{mk(REQ_UDEC, 64'd7, 5, 1, 3, 0, 0, SIGN_MINUS, 0, 0),
                              "    007"};
        directed_rows[18] = '{mk(REQ_UDEC, 64'd12345, 3, 0, 0, 0, 0, SIGN_MINUS, 0, 0),
                              "12345"};
        directed_rows[19] = '{mk(REQ_SDEC, ~64'd6, 4, 0, 0, 1, 0, SIGN_MINUS, 0, 0), "-0007"};
        directed_rows[20] = '{mk(REQ_SDEC, 64'd3, 31, 1, 31, 0, 1, SIGN_ALWAYS, 0, 0), ""};
        directed_rows[21] = '{mk(REQ_HEX, 64'hA, 31, 1, 31, 1, 0, SIGN_MINUS, 1, 0), ""};
        directed_rows[22] = '{mk(REQ_UDEC, 64'd0, 31, 1, 31, 0, 0, SIGN_MINUS, 0, 0), ""};
        directed_rows[23] = '{mk(REQ_HEX, 64'hDEAD_BEEF, 0, 0, 0, 0, 0, SIGN_MINUS, 0, 1),
                              "DEADBEEF"};
        directed_rows[24] = '{mk(REQ_SDEC, 64'd0, 0, 0, 0, 0, 0, SIGN_ALWAYS, 0, 0), "+0"};

        repeat (8) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        @(negedge clk);

        foreach (directed_rows[i]) send_item(directed_rows[i].item, directed_rows[i].text);
        repeat (RANDOM_ITEMS) send_item(random_item(), "");
        in_valid <= 1'b0;

        while (pending_chars.size() != 0) @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (mismatch_count == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule
